// ===== rtl/core/satd_pkg.sv =====
package satd_pkg;

    localparam int SAMPLE_BITS_DEF = 8;
    localparam int LANES           = 4;
    localparam int KEPT_ROWS       = 3;
    localparam int ROUND_BIAS      = 1;
    localparam int COLS_W          = 3;
    localparam int COST_W          = 15;
    localparam int COST_MAX        = 32767;
    localparam int PSUM_W          = 13;
    localparam int PSUM_MAX        = 8191;
    localparam int TOTAL_W         = 32;

    typedef struct packed {
        logic              full;
        logic              ulast;
        logic [PSUM_W-1:0] psum;
    } t_ctl;

endpackage

// ===== rtl/core/satd_if.sv =====
interface satd_in_if import satd_pkg::*; #(
    parameter int RES_W = SAMPLE_BITS_DEF + 1
) ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res0;
    logic signed [RES_W-1:0] res1;
    logic signed [RES_W-1:0] res2;
    logic signed [RES_W-1:0] res3;
    logic [COLS_W-1:0]       cols_used;
    logic                    tile_full;
    logic                    tile_last_row;
    logic                    unit_last;

    modport source (
        output valid, res0, res1, res2, res3, cols_used, tile_full, tile_last_row, unit_last,
        input  ready
    );
    modport sink (
        input  valid, res0, res1, res2, res3, cols_used, tile_full, tile_last_row, unit_last,
        output ready
    );
endinterface

interface satd_out_if import satd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COST_W-1:0]  tile_cost;
    logic [TOTAL_W-1:0] unit_total;
    logic               unit_done;

    modport source (
        output valid, tile_cost, unit_total, unit_done,
        input  ready
    );
    modport sink (
        input  valid, tile_cost, unit_total, unit_done,
        output ready
    );
endinterface

// ===== rtl/core/satd_hadamard4.sv =====
module satd_hadamard4 import satd_pkg::*; #(
    parameter int IN_W = SAMPLE_BITS_DEF + 1
) (
    input  logic signed [IN_W-1:0] i_s [LANES],
    output logic signed [IN_W+1:0] o_h [LANES]
);
    localparam int A_W = IN_W + 1;
    localparam int O_W = IN_W + 2;

    logic signed [A_W-1:0] w_a0, w_a1, w_a2, w_a3;

    assign w_a0 = A_W'(i_s[0]) + A_W'(i_s[3]);
    assign w_a1 = A_W'(i_s[1]) + A_W'(i_s[2]);
    assign w_a2 = A_W'(i_s[1]) - A_W'(i_s[2]);
    assign w_a3 = A_W'(i_s[0]) - A_W'(i_s[3]);

    assign o_h[0] = O_W'(w_a0) + O_W'(w_a1);
    assign o_h[1] = O_W'(w_a3) + O_W'(w_a2);
    assign o_h[2] = O_W'(w_a0) - O_W'(w_a1);
    assign o_h[3] = O_W'(w_a3) - O_W'(w_a2);
endmodule

// ===== rtl/core/satd_lane.sv =====
module satd_lane import satd_pkg::*; #(
    parameter int IN_W = SAMPLE_BITS_DEF + 3
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [IN_W-1:0] i_col [LANES],
    output logic [IN_W+3:0]        o_sum
);
    localparam int D_W = IN_W + 2;
    localparam int S_W = IN_W + 4;

    logic signed [D_W-1:0] w_d   [LANES];
    logic [D_W-1:0]        w_mag [LANES];
    logic [S_W-1:0]        n_sum;
    logic [S_W-1:0]        r_sum;

    satd_hadamard4 #(.IN_W(IN_W)) u_vert (
        .i_s (i_col),
        .o_h (w_d)
    );

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_mag[i] = w_d[i][D_W-1] ? D_W'(-w_d[i]) : D_W'(w_d[i]);
            n_sum    = n_sum + S_W'(w_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
endmodule

// ===== rtl/core/satd_merge.sv =====
module satd_merge import satd_pkg::*; #(
    parameter int LANE_W = SAMPLE_BITS_DEF + 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_ctl              i_ctl,
    input  logic [LANE_W-1:0] i_lane_sum [LANES],
    output logic              o_ready,
    satd_out_if.source        o_res
);
    localparam int SUM_W = LANE_W + 2;
    localparam int CF_W  = LANE_W + 1;

    logic [SUM_W-1:0]   w_sum;
    logic [CF_W-1:0]    w_cf;
    logic [COST_W-1:0]  w_cost_full;
    logic [COST_W-1:0]  n_cost;
    logic [TOTAL_W:0]   w_total_wide;
    logic [TOTAL_W-1:0] n_total;
    logic               w_rdy3, w_rdy4;

    logic               r_v3, r_v4;
    logic [COST_W-1:0]  r_cost3;
    logic               r_ulast3;
    logic [TOTAL_W-1:0] r_acc;
    logic [COST_W-1:0]  r_out_cost;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_done;

    always_comb begin
        w_sum = SUM_W'(ROUND_BIAS);
        for (int i = 0; i < LANES; i++) begin
            w_sum = w_sum + SUM_W'(i_lane_sum[i]);
        end
    end

    assign w_cf        = CF_W'(w_sum >> 1);
    assign w_cost_full = (w_cf > CF_W'(COST_MAX)) ? COST_W'(COST_MAX) : w_cf[COST_W-1:0];
    assign n_cost      = i_ctl.full ? w_cost_full : COST_W'(i_ctl.psum);

    assign w_total_wide = {1'b0, r_acc} + (TOTAL_W+1)'(r_cost3);
    assign n_total      = w_total_wide[TOTAL_W] ? '1 : w_total_wide[TOTAL_W-1:0];

    assign w_rdy4  = !r_v4 || o_res.ready;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign o_ready = w_rdy3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_acc <= '0;
        end else begin
            if (w_rdy3) begin
                r_v3 <= i_valid;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
                if (r_v3) begin
                    r_acc <= r_ulast3 ? '0 : n_total;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            r_cost3  <= n_cost;
            r_ulast3 <= i_ctl.ulast;
        end
        if (w_rdy4) begin
            r_out_cost  <= r_cost3;
            r_out_total <= n_total;
            r_out_done  <= r_ulast3;
        end
    end

    assign o_res.valid      = r_v4;
    assign o_res.tile_cost  = r_out_cost;
    assign o_res.unit_total = r_out_total;
    assign o_res.unit_done  = r_out_done;

    a_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy4 && r_v3 && r_ulast3) |=> (r_acc == '0))
        else $error("unit total not cleared after closing tile");

    a_total_ge_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_out_total >= TOTAL_W'(r_out_cost)))
        else $error("unit total below tile cost");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !o_res.ready) |=> (r_v4 && $stable(r_out_total)))
        else $error("stalled result changed");
endmodule

// ===== rtl/core/satd_4x4_hadamard_accumulator.sv =====
// A tile's last row, once accepted, is registered through the column stage, the lane sums
// and both merge stages before its result is valid.
// One row transaction per cycle while no stage is stalled; one result per tile, none for other rows.
// After the row transform come four column lanes (vertical transform) and a two-stage merge.
// Reset (synchronous, active low) clears row count, partial sum, unit total and valids;
// kept row transforms are not cleared.
module satd_4x4_hadamard_accumulator import satd_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    satd_in_if.sink    i_in,
    satd_out_if.source o_res
);
    localparam int RES_W  = SAMPLE_BITS + 1;
    localparam int H_W    = SAMPLE_BITS + 3;
    localparam int LANE_W = H_W + 4;
    localparam int RS_W   = SAMPLE_BITS + 3;
    localparam int PW     = ((RS_W > PSUM_W) ? RS_W : PSUM_W) + 1;

    logic signed [RES_W-1:0] w_s   [LANES];
    logic [RES_W-1:0]        w_mag [LANES];
    logic signed [H_W-1:0]   w_h   [LANES];
    logic [RS_W-1:0]         w_rsum;
    logic [PW-1:0]           w_psum_wide;
    logic [PSUM_W-1:0]       n_psum;
    logic                    w_acc, w_acc_last;
    logic                    w_rdy1, w_rdy2, w_rdy3;
    logic [LANE_W-1:0]       w_lane_sum [LANES];

    logic signed [H_W-1:0]   r_rows [KEPT_ROWS][LANES];
    logic [1:0]              r_row_cnt;
    logic [PSUM_W-1:0]       r_psum;
    logic                    r_v1, r_v2;
    logic signed [H_W-1:0]   r_col [LANES][LANES];
    t_ctl                    r_ctl1, r_ctl2;

    assign w_s[0] = i_in.res0;
    assign w_s[1] = i_in.res1;
    assign w_s[2] = i_in.res2;
    assign w_s[3] = i_in.res3;

    satd_hadamard4 #(.IN_W(RES_W)) u_hrow (
        .i_s (w_s),
        .o_h (w_h)
    );

    always_comb begin
        w_rsum = '0;
        for (int i = 0; i < LANES; i++) begin
            w_mag[i] = w_s[i][RES_W-1] ? RES_W'(-w_s[i]) : RES_W'(w_s[i]);
            if (COLS_W'(i) < i_in.cols_used) begin
                w_rsum = w_rsum + RS_W'(w_mag[i]);
            end
        end
    end

    assign w_psum_wide = PW'(r_psum) + PW'(w_rsum);
    assign n_psum      = (w_psum_wide > PW'(PSUM_MAX)) ? PSUM_W'(PSUM_MAX)
                                                       : w_psum_wide[PSUM_W-1:0];

    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_in.ready  = w_rdy1;
    assign w_acc       = i_in.valid && w_rdy1;
    assign w_acc_last  = w_acc && i_in.tile_last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
            r_psum    <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
        end else begin
            if (w_acc) begin
                if (i_in.tile_last_row) begin
                    r_row_cnt <= '0;
                    r_psum    <= '0;
                end else begin
                    r_psum <= n_psum;
                    if (r_row_cnt != 2'(KEPT_ROWS)) begin
                        r_row_cnt <= r_row_cnt + 2'd1;
                    end
                end
            end
            if (w_rdy1) begin
                r_v1 <= w_acc_last;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && !i_in.tile_last_row && r_row_cnt != 2'(KEPT_ROWS)) begin
            r_rows[r_row_cnt] <= w_h;
        end
        if (w_rdy1) begin
            for (int k = 0; k < LANES; k++) begin
                for (int j = 0; j < KEPT_ROWS; j++) begin
                    r_col[k][j] <= r_rows[j][k];
                end
                r_col[k][KEPT_ROWS] <= w_h[k];
            end
            r_ctl1 <= '{full: i_in.tile_full, ulast: i_in.unit_last, psum: n_psum};
        end
        if (w_rdy2) begin
            r_ctl2 <= r_ctl1;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        satd_lane #(.IN_W(H_W)) u_lane (
            .i_clk (i_clk),
            .i_en  (w_rdy2),
            .i_col (r_col[k]),
            .o_sum (w_lane_sum[k])
        );
    end

    satd_merge #(.LANE_W(LANE_W)) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v2),
        .i_ctl      (r_ctl2),
        .i_lane_sum (w_lane_sum),
        .o_ready    (w_rdy3),
        .o_res      (o_res)
    );

    a_row_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_last |=> (r_row_cnt == '0 && r_psum == '0))
        else $error("row state not cleared after last row");

    a_v1_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v1) |-> $past(w_acc_last))
        else $error("tile entered pipeline without a last row");

    a_v1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_rdy2) |=> (r_v1 && $stable(r_ctl1)))
        else $error("stalled tile lost in first stage");
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import satd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RES_W       = SAMPLE_BITS_DEF + 1;
    localparam int RES_MAG     = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_ROWS = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTS  = 40;

    typedef struct packed {
        logic signed [RES_W-1:0] res0;
        logic signed [RES_W-1:0] res1;
        logic signed [RES_W-1:0] res2;
        logic signed [RES_W-1:0] res3;
        logic [COLS_W-1:0]       cols;
        logic                    full;
        logic                    last;
        logic                    ulast;
    } t_res_row;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [TOTAL_W-1:0] total;
        logic               done;
    } t_tile_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    satd_in_if #(.RES_W(RES_W)) in_if ();
    satd_out_if                 res_if ();

    satd_4x4_hadamard_accumulator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    int              kept_h [KEPT_ROWS][LANES];
    logic [2:0]      kept_valid;
    int unsigned     rows_in_tile;
    int unsigned     psum_acc;
    longint unsigned unit_acc;

    t_tile_res expected_costs[$];
    t_tile_res want;

    bit          idle_on;
    int          res_stall;
    int          hold_left;
    int          err_cnt;
    int          rows_sent;
    int unsigned cycles;

    task automatic flag_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
    endtask

    function automatic int unsigned mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic void wht4(input int s[LANES], output int o[LANES]);
        int a0, a1, a2, a3;
        a0 = s[0] + s[3];
        a1 = s[1] + s[2];
        a2 = s[1] - s[2];
        a3 = s[0] - s[3];
        o[0] = a0 + a1;
        o[1] = a3 + a2;
        o[2] = a0 - a1;
        o[3] = a3 - a2;
    endfunction

    function automatic void predict_satd(input t_res_row r);
        int              s [LANES];
        int              h [LANES];
        int              col [LANES];
        int              d [LANES];
        int unsigned     ncols, rsum, psum, sum, cost;
        longint unsigned total;
        t_tile_res       e;
        s[0] = r.res0;
        s[1] = r.res1;
        s[2] = r.res2;
        s[3] = r.res3;
        ncols = (r.cols > LANES) ? LANES : r.cols;
        rsum = 0;
        for (int i = 0; i < ncols; i++)
            rsum += mag(s[i]);
        wht4(s, h);
        psum = psum_acc + rsum;
        if (psum > PSUM_MAX)
            psum = PSUM_MAX;

        if (!r.last) begin
            // rows beyond the third are summed but not kept
            if (rows_in_tile < KEPT_ROWS) begin
                for (int i = 0; i < LANES; i++)
                    kept_h[rows_in_tile][i] = h[i];
                kept_valid[rows_in_tile] = 1'b1;
                rows_in_tile++;
            end
            psum_acc = psum;
            return;
        end

        if (r.full) begin
            sum = 0;
            for (int k = 0; k < LANES; k++) begin
                col[0] = kept_h[0][k];
                col[1] = kept_h[1][k];
                col[2] = kept_h[2][k];
                col[3] = h[k];
                wht4(col, d);
                for (int i = 0; i < LANES; i++)
                    sum += mag(d[i]);
            end
            cost = (sum + ROUND_BIAS) >> 1;
        end else begin
            cost = psum;
        end
        if (cost > COST_MAX)
            cost = COST_MAX;

        total = unit_acc + cost;
        if (total > 64'hFFFF_FFFF)
            total = 64'hFFFF_FFFF;

        e.cost  = cost[COST_W-1:0];
        e.total = total[TOTAL_W-1:0];
        e.done  = r.ulast;
        expected_costs = {expected_costs, e};

        unit_acc     = r.ulast ? 0 : total;
        rows_in_tile = 0;
        psum_acc     = 0;
    endfunction

    function automatic logic signed [RES_W-1:0] rand_sample();
        unique case ($urandom_range(0, 9))
            0:       return RES_W'(RES_MAG);
            1:       return RES_W'(-RES_MAG);
            2:       return '0;
            default: return RES_W'($urandom_range(0, 2 * RES_MAG) - RES_MAG);
        endcase
    endfunction

    function automatic t_res_row row_of(input int a, input int b, input int c, input int d,
                                        input logic [COLS_W-1:0] cols, input logic full,
                                        input logic last, input logic ulast);
        t_res_row r;
        r.res0  = RES_W'(a);
        r.res1  = RES_W'(b);
        r.res2  = RES_W'(c);
        r.res3  = RES_W'(d);
        r.cols  = cols;
        r.full  = full;
        r.last  = last;
        r.ulast = ulast;
        return r;
    endfunction

    // Starts and ends on a falling edge; valid stays high into the next transaction
    task automatic send_row(input t_res_row r);
        int gap;
        // a full tile may never close on kept rows that were never written
        if (r.last && r.full && kept_valid != 3'b111)
            r.full = 1'b0;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.res0          <= r.res0;
        in_if.res1          <= r.res1;
        in_if.res2          <= r.res2;
        in_if.res3          <= r.res3;
        in_if.cols_used     <= r.cols;
        in_if.tile_full     <= r.full;
        in_if.tile_last_row <= r.last;
        in_if.unit_last     <= r.ulast;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        predict_satd(r);
        rows_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_tile(input int nrows, input logic full, input logic [COLS_W-1:0] cols,
                             input logic ulast);
        bit last;
        for (int n = 0; n < nrows; n++) begin
            last = (n == nrows - 1);
            send_row(row_of(rand_sample(), rand_sample(), rand_sample(), rand_sample(), cols,
                            last ? full : 1'($urandom_range(0, 1)), last,
                            last ? ulast : 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic test_full_tiles();
        idle_on = 1'b0;
        for (int n = 0; n < 4; n++)
            send_row(row_of(0, 0, 0, 0, 3'd4, 1'b1, n == 3, 1'b0));
        for (int n = 0; n < 4; n++)
            send_row(row_of(RES_MAG, RES_MAG, RES_MAG, RES_MAG, 3'd4, 1'b1, n == 3, 1'b0));
        for (int n = 0; n < 4; n++) begin
            if (n % 2 == 0)
                send_row(row_of(RES_MAG, -RES_MAG, RES_MAG, -RES_MAG, 3'd4, 1'b1, n == 3, 1'b1));
            else
                send_row(row_of(-RES_MAG, RES_MAG, -RES_MAG, RES_MAG, 3'd4, 1'b1, n == 3, 1'b1));
        end
    endtask

    task automatic test_tile_corners();
        idle_on = 1'b1;
        // over-long full tile: rows four and five must not overwrite the kept rows
        send_row(row_of(17, -3, 250, -255, 3'd4, 1'b1, 1'b0, 1'b0));
        send_row(row_of(-128, 64, 0, 99, 3'd4, 1'b1, 1'b0, 1'b0));
        send_row(row_of(255, 255, -1, 1, 3'd4, 1'b1, 1'b0, 1'b0));
        send_row(row_of(-255, -255, -255, -255, 3'd4, 1'b1, 1'b0, 1'b0));
        send_row(row_of(5, -7, 11, -13, 3'd4, 1'b1, 1'b1, 1'b0));
        // early close: older kept rows fill the gap
        send_row(row_of(-40, 200, -255, 128, 3'd4, 1'b1, 1'b0, 1'b0));
        send_row(row_of(1, -1, 255, 0, 3'd4, 1'b1, 1'b1, 1'b0));
        // partial tile driven into saturation, with zero and out-of-range column counts
        send_row(row_of(RES_MAG, RES_MAG, RES_MAG, RES_MAG, 3'd0, 1'b0, 1'b0, 1'b0));
        for (int n = 0; n < 9; n++)
            send_row(row_of(RES_MAG, -RES_MAG, RES_MAG, -RES_MAG, 3'(4 + n % 4), 1'b0,
                            n == 8, n == 8));
    endtask

    task automatic test_random_units();
        int          ntiles, kind, nrows, start;
        logic [COLS_W-1:0] cols;
        start = rows_sent;
        while (rows_sent - start < RANDOM_ROWS) begin
            ntiles = $urandom_range(1, 6);
            for (int t = 0; t < ntiles; t++) begin
                idle_on = ((rows_sent / 120) % 3) != 0;
                kind = $urandom_range(0, 99);
                if (kind < 55) begin
                    send_tile(4, 1'b1, 3'($urandom_range(1, 4)), t == ntiles - 1);
                end else if (kind < 75) begin
                    send_tile($urandom_range(1, 4), 1'b0, 3'($urandom_range(1, 4)),
                              t == ntiles - 1);
                end else if (kind < 85) begin
                    send_tile($urandom_range(1, 3), 1'b1, 3'($urandom_range(1, 4)),
                              t == ntiles - 1);
                end else if (kind < 92) begin
                    send_tile($urandom_range(5, 9), 1'($urandom_range(0, 1)),
                              3'($urandom_range(0, 7)), t == ntiles - 1);
                end else begin
                    nrows = $urandom_range(1, 4);
                    for (int n = 0; n < nrows; n++) begin
                        cols = COLS_W'($urandom_range(0, 7));
                        send_row(row_of(rand_sample(), rand_sample(), rand_sample(),
                                        rand_sample(), cols, 1'($urandom_range(0, 1)),
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                    end
                end
            end
        end
    endtask

    task automatic test_backpressure();
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int n = 0; n < 60; n++)
            send_tile(1, 1'b0, 3'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
    endtask

    // result receiver: per-result stall, plus the long hold-off
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                res_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (res_stall > 0) begin
                res_if.ready <= 1'b0;
                res_stall = res_stall - 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_costs.size() == 0) begin
                flag_mismatch("unexpected tile result, cost", 0, res_if.tile_cost);
            end else begin
                want = expected_costs.pop_front();
                if (res_if.tile_cost !== want.cost)
                    flag_mismatch("tile_cost", want.cost, res_if.tile_cost);
                if (res_if.unit_total !== want.total)
                    flag_mismatch("unit_total", want.total, res_if.unit_total);
                if (res_if.unit_done !== want.done)
                    flag_mismatch("unit_done", want.done, res_if.unit_done);
            end
            res_stall = idle_on ? $urandom_range(0, 7) : 0;
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.res0          = '0;
        in_if.res1          = '0;
        in_if.res2          = '0;
        in_if.res3          = '0;
        in_if.cols_used     = '0;
        in_if.tile_full     = 1'b0;
        in_if.tile_last_row = 1'b0;
        in_if.unit_last     = 1'b0;
        kept_valid          = '0;
        rows_in_tile        = 0;
        psum_acc            = 0;
        unit_acc            = 0;
        idle_on             = 1'b0;
        res_stall           = 0;
        hold_left           = 0;
        err_cnt             = 0;
        rows_sent           = 0;
        for (int r = 0; r < KEPT_ROWS; r++)
            for (int c = 0; c < LANES; c++)
                kept_h[r][c] = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_full_tiles();
        test_tile_corners();
        test_random_units();
        test_backpressure();
        test_random_units();

        in_if.valid <= 1'b0;
        while (expected_costs.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== satd_4x4_hadamard_accumulator.f =====
rtl/core/satd_pkg.sv
rtl/core/satd_if.sv
rtl/core/satd_hadamard4.sv
rtl/core/satd_lane.sv
rtl/core/satd_merge.sv
rtl/core/satd_4x4_hadamard_accumulator.sv
tb/sv/tb_top.sv
